[design/clcd_pkg.sv]
// Shared types, constants and the microcode program for the character-LCD command sequencer.
// No dependencies; every design file except clcd_ifs.sv imports this package.
package clcd_pkg;

    localparam int PC_W       = 6;
    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int IDX_W      = 4;

    // Command opcodes
    localparam logic [3:0] OPC_INIT    = 4'd0;
    localparam logic [3:0] OPC_CHAR    = 4'd1;
    localparam logic [3:0] OPC_CLEAR   = 4'd2;
    localparam logic [3:0] OPC_SETCUR  = 4'd3;
    localparam logic [3:0] OPC_CLRLOC  = 4'd4;
    localparam logic [3:0] OPC_BKSP    = 4'd5;
    localparam logic [3:0] OPC_DECIMAL = 4'd6;
    localparam logic [3:0] OPC_BIN_TRIM = 4'd7;
    localparam logic [3:0] OPC_BIN8    = 4'd8;
    localparam logic [3:0] OPC_HEX     = 4'd9;

    // Display instructions
    localparam logic [7:0] LCD_FUNC_8BIT = 8'h38;
    localparam logic [7:0] LCD_FUNC_4BIT = 8'h28;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [7:0] LCD_CLR_DISP  = 8'h01;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_HOME      = 8'h02;
    localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
    localparam logic [7:0] LCD_ROW1      = 8'h40;

    // Characters
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_ALPHA = 8'h37;

    typedef enum logic [3:0] {
        UOP_SEND_K,
        UOP_CHAR,
        UOP_FWD,
        UOP_BACK,
        UOP_GOTO,
        UOP_HOME,
        UOP_JMP,
        UOP_JMP_NIB,
        UOP_JMP_POS,
        UOP_BCD_START,
        UOP_BCD_WAIT,
        UOP_SET_IDX,
        UOP_SKIP_DIG,
        UOP_SKIP_BIT,
        UOP_LOOP,
        UOP_END
    } uop_t;

    typedef enum logic [2:0] {
        CS_INPUT,
        CS_SPACE,
        CS_MINUS,
        CS_DIGIT,
        CS_BIT,
        CS_HEX_HI,
        CS_HEX_LO
    } csrc_t;

    typedef logic [PC_W-1:0] upc_t;

    typedef struct packed {
        uop_t       op;
        csrc_t      src;
        logic [7:0] konst;
        upc_t       target;
    } uword_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // Sequencer to output stage: one transfer or the end-of-command mark
    typedef struct packed {
        logic       send;
        logic       fin;
        logic       rs;
        logic [7:0] bus;
    } oq_req_t;

    localparam upc_t EP_INIT     = 6'd0;
    localparam upc_t EP_CLEAR    = 6'd10;
    localparam upc_t EP_SETCUR   = 6'd13;
    localparam upc_t EP_CLRLOC   = 6'd15;
    localparam upc_t EP_CHAR     = 6'd19;
    localparam upc_t EP_BKSP     = 6'd22;
    localparam upc_t EP_DECIMAL  = 6'd27;
    localparam upc_t EP_BIN_TRIM = 6'd38;
    localparam upc_t EP_BIN8     = 6'd44;
    localparam upc_t EP_HEX      = 6'd49;
    localparam upc_t EP_NONE     = 6'd53;

    function automatic uword_t mk(uop_t op, csrc_t src, logic [7:0] k, upc_t t);
        uword_t w;
        w.op     = op;
        w.src    = src;
        w.konst  = k;
        w.target = t;
        return w;
    endfunction

    function automatic uword_t ucode_rom(upc_t pc);
        uword_t w;
        case (pc)
            // init
            6'd0:  w = mk(UOP_JMP_NIB,   CS_INPUT,  8'h00,         6'd3);
            6'd1:  w = mk(UOP_SEND_K,    CS_INPUT,  LCD_FUNC_8BIT, 6'd0);
            6'd2:  w = mk(UOP_JMP,       CS_INPUT,  8'h00,         6'd5);
            6'd3:  w = mk(UOP_SEND_K,    CS_INPUT,  LCD_HOME,      6'd0);
            6'd4:  w = mk(UOP_SEND_K,    CS_INPUT,  LCD_FUNC_4BIT, 6'd0);
            6'd5:  w = mk(UOP_SEND_K,    CS_INPUT,  LCD_DISP_ON,   6'd0);
            6'd6:  w = mk(UOP_SEND_K,    CS_INPUT,  LCD_CLR_DISP,  6'd0);
            6'd7:  w = mk(UOP_SEND_K,    CS_INPUT,  LCD_ENTRY,     6'd0);
            6'd8:  w = mk(UOP_HOME,      CS_INPUT,  8'h00,         6'd0);
            6'd9:  w = mk(UOP_END,       CS_INPUT,  8'h00,         6'd0);
            // clear
            6'd10: w = mk(UOP_SEND_K,    CS_INPUT,  LCD_CLR_DISP,  6'd0);
            6'd11: w = mk(UOP_HOME,      CS_INPUT,  8'h00,         6'd0);
            6'd12: w = mk(UOP_END,       CS_INPUT,  8'h00,         6'd0);
            // set cursor
            6'd13: w = mk(UOP_GOTO,      CS_INPUT,  8'h00,         6'd0);
            6'd14: w = mk(UOP_END,       CS_INPUT,  8'h00,         6'd0);
            // clear location
            6'd15: w = mk(UOP_GOTO,      CS_INPUT,  8'h00,         6'd0);
            6'd16: w = mk(UOP_CHAR,      CS_SPACE,  8'h00,         6'd0);
            6'd17: w = mk(UOP_FWD,       CS_INPUT,  8'h00,         6'd0);
            6'd18: w = mk(UOP_END,       CS_INPUT,  8'h00,         6'd0);
            // character
            6'd19: w = mk(UOP_CHAR,      CS_INPUT,  8'h00,         6'd0);
            6'd20: w = mk(UOP_FWD,       CS_INPUT,  8'h00,         6'd0);
            6'd21: w = mk(UOP_END,       CS_INPUT,  8'h00,         6'd0);
            // backspace
            6'd22: w = mk(UOP_BACK,      CS_INPUT,  8'h00,         6'd0);
            6'd23: w = mk(UOP_CHAR,      CS_SPACE,  8'h00,         6'd0);
            6'd24: w = mk(UOP_FWD,       CS_INPUT,  8'h00,         6'd0);
            6'd25: w = mk(UOP_BACK,      CS_INPUT,  8'h00,         6'd0);
            6'd26: w = mk(UOP_END,       CS_INPUT,  8'h00,         6'd0);
            // signed decimal
            6'd27: w = mk(UOP_BCD_START, CS_INPUT,  8'h00,         6'd0);
            6'd28: w = mk(UOP_JMP_POS,   CS_INPUT,  8'h00,         6'd31);
            6'd29: w = mk(UOP_CHAR,      CS_MINUS,  8'h00,         6'd0);
            6'd30: w = mk(UOP_FWD,       CS_INPUT,  8'h00,         6'd0);
            6'd31: w = mk(UOP_BCD_WAIT,  CS_INPUT,  8'h00,         6'd0);
            6'd32: w = mk(UOP_SET_IDX,   CS_INPUT,  8'd9,          6'd0);
            6'd33: w = mk(UOP_SKIP_DIG,  CS_INPUT,  8'h00,         6'd0);
            6'd34: w = mk(UOP_CHAR,      CS_DIGIT,  8'h00,         6'd0);
            6'd35: w = mk(UOP_FWD,       CS_INPUT,  8'h00,         6'd0);
            6'd36: w = mk(UOP_LOOP,      CS_INPUT,  8'h00,         6'd34);
            6'd37: w = mk(UOP_END,       CS_INPUT,  8'h00,         6'd0);
            // trimmed binary
            6'd38: w = mk(UOP_SET_IDX,   CS_INPUT,  8'd7,          6'd0);
            6'd39: w = mk(UOP_SKIP_BIT,  CS_INPUT,  8'h00,         6'd43);
            6'd40: w = mk(UOP_CHAR,      CS_BIT,    8'h00,         6'd0);
            6'd41: w = mk(UOP_FWD,       CS_INPUT,  8'h00,         6'd0);
            6'd42: w = mk(UOP_LOOP,      CS_INPUT,  8'h00,         6'd40);
            6'd43: w = mk(UOP_END,       CS_INPUT,  8'h00,         6'd0);
            // 8-bit binary
            6'd44: w = mk(UOP_SET_IDX,   CS_INPUT,  8'd7,          6'd0);
            6'd45: w = mk(UOP_CHAR,      CS_BIT,    8'h00,         6'd0);
            6'd46: w = mk(UOP_FWD,       CS_INPUT,  8'h00,         6'd0);
            6'd47: w = mk(UOP_LOOP,      CS_INPUT,  8'h00,         6'd45);
            6'd48: w = mk(UOP_END,       CS_INPUT,  8'h00,         6'd0);
            // hex
            6'd49: w = mk(UOP_CHAR,      CS_HEX_HI, 8'h00,         6'd0);
            6'd50: w = mk(UOP_FWD,       CS_INPUT,  8'h00,         6'd0);
            6'd51: w = mk(UOP_CHAR,      CS_HEX_LO, 8'h00,         6'd0);
            6'd52: w = mk(UOP_FWD,       CS_INPUT,  8'h00,         6'd0);
            default: w = mk(UOP_END,     CS_INPUT,  8'h00,         6'd0);
        endcase
        return w;
    endfunction

    function automatic upc_t entry_pc(logic [3:0] opc);
        upc_t p;
        case (opc)
            OPC_INIT:     p = EP_INIT;
            OPC_CHAR:     p = EP_CHAR;
            OPC_CLEAR:    p = EP_CLEAR;
            OPC_SETCUR:   p = EP_SETCUR;
            OPC_CLRLOC:   p = EP_CLRLOC;
            OPC_BKSP:     p = EP_BKSP;
            OPC_DECIMAL:  p = EP_DECIMAL;
            OPC_BIN_TRIM: p = EP_BIN_TRIM;
            OPC_BIN8:     p = EP_BIN8;
            OPC_HEX:      p = EP_HEX;
            default:      p = EP_NONE;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        logic [7:0] c;
        if (nib <= 4'd9)
        begin
            c = CHR_ZERO + {4'h0, nib};
        end
        else
        begin
            c = CHR_ALPHA + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

[design/clcd_ifs.sv]
// Handshake interfaces for the command channel and the bus-transfer channel.
// Standalone; no package needed.
interface clcd_cmd_if;
    logic               valid;
    logic               ready;
    logic [3:0]         opcode;
    logic signed [31:0] value;
    logic               row;
    logic [3:0]         column;

    modport source (output valid, output opcode, output value, output row, output column,
                    input ready);
    modport sink   (input valid, input opcode, input value, input row, input column,
                    output ready);
endinterface

interface clcd_xfer_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] bus_value;
    logic       last_transfer;

    modport source (output valid, output reg_select, output bus_value, output last_transfer,
                    input ready);
    modport sink   (input valid, input reg_select, input bus_value, input last_transfer,
                    output ready);
endinterface

[design/clcd_bcd_conv.sv]
// Binary to BCD converter (shift-and-add-3), two bits per cycle.
// Depends on clcd_pkg.
module clcd_bcd_conv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [clcd_pkg::VALUE_W-1:0] mag,
    output logic                       busy,
    output logic [clcd_pkg::BCD_W-1:0] digits
);
    import clcd_pkg::*;

    logic               busy_reg, busy_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;

    function automatic logic [BCD_W-1:0] dd_step(logic [BCD_W-1:0] b, logic in_bit);
        logic [BCD_W-1:0] adj;
        adj = b;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (adj[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], in_bit};
    endfunction

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            bin_next  = mag;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = dd_step(dd_step(bcd_reg, bin_reg[VALUE_W-1]), bin_reg[VALUE_W-2]);
            bin_next = {bin_reg[VALUE_W-3:0], 2'b00};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'hF)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy   = busy_reg;
    assign digits = bcd_reg;

endmodule

[design/clcd_out_stage.sv]
// Output stage: holds one transfer back until the next one or the end of the command is known,
// so the final transfer can be tagged, then registers it onto the bus channel. Uses clcd_pkg.
module clcd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  clcd_pkg::oq_req_t req,
    output logic              room,
    clcd_xfer_if.source       xfer
);
    import clcd_pkg::*;

    logic       pend_valid_reg, pend_valid_next;
    logic       pend_rs_reg, pend_rs_next;
    logic [7:0] pend_bus_reg, pend_bus_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_rs_reg, out_rs_next;
    logic [7:0] out_bus_reg, out_bus_next;
    logic       out_last_reg, out_last_next;
    logic       out_free;

    assign out_free = !out_valid_reg || xfer.ready;
    assign room     = !pend_valid_reg || out_free;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_rs_next    = pend_rs_reg;
        pend_bus_next   = pend_bus_reg;
        out_valid_next  = out_valid_reg && !xfer.ready;
        out_rs_next     = out_rs_reg;
        out_bus_next    = out_bus_reg;
        out_last_next   = out_last_reg;
        if (req.send && room)
        begin
            // push the held transfer out, hold the new one
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_rs_next    = pend_rs_reg;
                out_bus_next   = pend_bus_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_rs_next    = req.rs;
            pend_bus_next   = req.bus;
        end
        else if (req.fin && room && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_rs_next     = pend_rs_reg;
            out_bus_next    = pend_bus_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_rs_reg  <= pend_rs_next;
        pend_bus_reg <= pend_bus_next;
        out_rs_reg   <= out_rs_next;
        out_bus_reg  <= out_bus_next;
        out_last_reg <= out_last_next;
    end

    assign xfer.valid         = out_valid_reg;
    assign xfer.reg_select    = out_rs_reg;
    assign xfer.bus_value     = out_bus_reg;
    assign xfer.last_transfer = out_last_reg;

`ifndef SYNTH
    a_push_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        req.send && room && pend_valid_reg |=> out_valid_reg && !out_last_reg)
        else $error("held transfer not pushed on a following transfer");
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        !req.send && req.fin && room && pend_valid_reg |=> out_valid_reg && out_last_reg)
        else $error("final transfer not tagged");
    a_fin_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !req.send && req.fin && room |=> !pend_valid_reg)
        else $error("transfer still held after end of command");
`endif

endmodule

[design/clcd_sequencer.sv]
// Microcoded command sequencer: step counter, program table from clcd_pkg, cursor tracking,
// nibble splitting and character formatting. Uses clcd_pkg and clcd_cmd_if.
module clcd_sequencer #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    clcd_cmd_if.sink                     cmd,
    input  logic                         nibble_mode,
    output clcd_pkg::oq_req_t            req,
    input  logic                         room,
    output logic                         bcd_start,
    output logic [clcd_pkg::VALUE_W-1:0] bcd_mag,
    input  logic                         bcd_busy,
    input  logic [clcd_pkg::BCD_W-1:0]   bcd_digits
);
    import clcd_pkg::*;

    localparam int               COL_W    = $clog2(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic             ROW_LAST = 1'(ROWS - 1);

    seq_state_t         state_reg, state_next;
    upc_t               pc_reg, pc_next;
    logic               phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               trow_reg, trow_next;
    logic [3:0]         tcol_reg, tcol_next;
    logic               cur_row_reg, cur_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;

    uword_t                       uw;
    logic [BCD_DIGITS-1:0][3:0]   dig_arr;
    logic [3:0]                   digit;
    logic                         bit_sel;
    logic                         fwd_row, back_row;
    logic [COL_W-1:0]             fwd_col, back_col;
    logic                         goto_ok;
    logic [7:0]                   char_byte;
    logic                         wants_send;
    logic                         send_rs;
    logic [7:0]                   send_byte;
    logic                         send_last;
    logic                         running;

    function automatic logic [7:0] ddram_addr(logic r, logic [COL_W-1:0] c);
        return LCD_SET_DDRAM | (r ? LCD_ROW1 : 8'h00) | 8'(c);
    endfunction

    assign uw      = ucode_rom(pc_reg);
    assign running = (state_reg == SEQ_RUN);
    assign dig_arr = bcd_digits;
    assign digit   = dig_arr[idx_reg];
    assign bit_sel = value_reg[idx_reg[2:0]];
    assign bcd_mag = value_reg[VALUE_W-1] ? (VALUE_W'(0) - value_reg) : value_reg;
    assign goto_ok = (int'(trow_reg) < ROWS) && (int'(tcol_reg) < COLUMNS);

    // cursor neighbours, wrapping over rows
    always_comb
    begin
        if (cur_col_reg >= COL_LAST)
        begin
            fwd_col = '0;
            fwd_row = (cur_row_reg >= ROW_LAST) ? 1'b0 : 1'b1;
        end
        else
        begin
            fwd_col = cur_col_reg + COL_W'(1);
            fwd_row = cur_row_reg;
        end
        if (cur_col_reg == '0)
        begin
            back_col = COL_LAST;
            back_row = (cur_row_reg == 1'b0) ? ROW_LAST : 1'b0;
        end
        else
        begin
            back_col = cur_col_reg - COL_W'(1);
            back_row = cur_row_reg;
        end
    end

    always_comb
    begin
        case (uw.src)
            CS_INPUT:  char_byte = value_reg[7:0];
            CS_SPACE:  char_byte = CHR_SPACE;
            CS_MINUS:  char_byte = CHR_MINUS;
            CS_DIGIT:  char_byte = CHR_ZERO | {4'h0, digit};
            CS_BIT:    char_byte = CHR_ZERO | {7'h00, bit_sel};
            CS_HEX_HI: char_byte = hex_char(value_reg[7:4]);
            CS_HEX_LO: char_byte = hex_char(value_reg[3:0]);
            default:   char_byte = CHR_SPACE;
        endcase
    end

    // control word decode: what byte, if any, this step puts on the bus
    always_comb
    begin
        wants_send = 1'b0;
        send_rs    = 1'b0;
        send_byte  = uw.konst;
        case (uw.op)
            UOP_SEND_K:
            begin
                wants_send = 1'b1;
            end
            UOP_CHAR:
            begin
                wants_send = 1'b1;
                send_rs    = 1'b1;
                send_byte  = char_byte;
            end
            UOP_FWD:
            begin
                wants_send = 1'b1;
                send_byte  = ddram_addr(fwd_row, fwd_col);
            end
            UOP_BACK:
            begin
                wants_send = 1'b1;
                send_byte  = ddram_addr(back_row, back_col);
            end
            UOP_GOTO:
            begin
                wants_send = goto_ok;
                send_byte  = ddram_addr(trow_reg, COL_W'(tcol_reg));
            end
            default:
            begin
                wants_send = 1'b0;
            end
        endcase
    end

    assign send_last = !nibble_mode || phase_reg;

    always_comb
    begin
        req.send = running && wants_send;
        req.fin  = running && (uw.op == UOP_END);
        req.rs   = send_rs;
        if (nibble_mode)
        begin
            req.bus = phase_reg ? {4'h0, send_byte[3:0]} : {4'h0, send_byte[7:4]};
        end
        else
        begin
            req.bus = send_byte;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                if ((uw.op == UOP_END) && room)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // step counter and datapath
    always_comb
    begin
        cmd.ready    = (state_reg == SEQ_IDLE);
        bcd_start    = 1'b0;
        pc_next      = pc_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        value_next   = value_reg;
        trow_next    = trow_reg;
        tcol_next    = tcol_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (cmd.valid)
                begin
                    value_next = cmd.value;
                    trow_next  = cmd.row;
                    tcol_next  = cmd.column;
                    pc_next    = entry_pc(cmd.opcode);
                    phase_next = 1'b0;
                end
            end
            SEQ_RUN:
            begin
                if (wants_send)
                begin
                    if (room && send_last)
                    begin
                        phase_next = 1'b0;
                        pc_next    = pc_reg + upc_t'(1);
                        case (uw.op)
                            UOP_FWD:
                            begin
                                cur_row_next = fwd_row;
                                cur_col_next = fwd_col;
                            end
                            UOP_BACK:
                            begin
                                cur_row_next = back_row;
                                cur_col_next = back_col;
                            end
                            UOP_GOTO:
                            begin
                                cur_row_next = trow_reg;
                                cur_col_next = COL_W'(tcol_reg);
                            end
                            default:
                            begin
                                cur_row_next = cur_row_reg;
                            end
                        endcase
                    end
                    else if (room)
                    begin
                        // high nibble gone, low nibble next
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    case (uw.op)
                        UOP_GOTO:
                        begin
                            pc_next = pc_reg + upc_t'(1);
                        end
                        UOP_HOME:
                        begin
                            cur_row_next = 1'b0;
                            cur_col_next = '0;
                            pc_next      = pc_reg + upc_t'(1);
                        end
                        UOP_JMP:
                        begin
                            pc_next = uw.target;
                        end
                        UOP_JMP_NIB:
                        begin
                            pc_next = nibble_mode ? uw.target : pc_reg + upc_t'(1);
                        end
                        UOP_JMP_POS:
                        begin
                            pc_next = !value_reg[VALUE_W-1] ? uw.target : pc_reg + upc_t'(1);
                        end
                        UOP_BCD_START:
                        begin
                            bcd_start = 1'b1;
                            pc_next   = pc_reg + upc_t'(1);
                        end
                        UOP_BCD_WAIT:
                        begin
                            if (!bcd_busy)
                            begin
                                pc_next = pc_reg + upc_t'(1);
                            end
                        end
                        UOP_SET_IDX:
                        begin
                            idx_next = uw.konst[IDX_W-1:0];
                            pc_next  = pc_reg + upc_t'(1);
                        end
                        UOP_SKIP_DIG:
                        begin
                            // drop leading zero digits, keep at least one
                            if ((digit == 4'd0) && (idx_reg != '0))
                            begin
                                idx_next = idx_reg - IDX_W'(1);
                            end
                            else
                            begin
                                pc_next = pc_reg + upc_t'(1);
                            end
                        end
                        UOP_SKIP_BIT:
                        begin
                            // an all-zero byte prints nothing
                            if (bit_sel)
                            begin
                                pc_next = pc_reg + upc_t'(1);
                            end
                            else if (idx_reg == '0)
                            begin
                                pc_next = uw.target;
                            end
                            else
                            begin
                                idx_next = idx_reg - IDX_W'(1);
                            end
                        end
                        UOP_LOOP:
                        begin
                            if (idx_reg != '0)
                            begin
                                idx_next = idx_reg - IDX_W'(1);
                                pc_next  = uw.target;
                            end
                            else
                            begin
                                pc_next = pc_reg + upc_t'(1);
                            end
                        end
                        default:
                        begin
                            pc_next = pc_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                pc_next = pc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_IDLE;
            pc_reg      <= '0;
            phase_reg   <= 1'b0;
            idx_reg     <= '0;
            cur_row_reg <= 1'b0;
            cur_col_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        trow_reg  <= trow_next;
        tcol_reg  <= tcol_next;
    end

`ifndef SYNTH
    a_phase_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> nibble_mode)
        else $error("low-nibble phase outside 4-bit mode");
    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> running && !phase_reg)
        else $error("accepted command did not start the program");
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cur_col_reg) < COLUMNS) && (int'(cur_row_reg) < ROWS))
        else $error("tracked cursor outside the display");
`endif

endmodule

[design/char_lcd_command_sequencer.sv]
// Top level of the character-LCD command sequencer: configuration register and the
// sequencer, BCD converter and output stage. Uses clcd_pkg, clcd_cmd_if and clcd_xfer_if.
//
// Takes one display command per cmd transaction and produces the bus transfers it needs on
// xfer, one transfer per cycle while xfer is ready, with last_transfer set on the final one.
// A command runs through its acceptance, one step per transfer (two per byte in 4-bit
// mode) and the non-sending microcode steps: jumps, loop tests, leading-zero skips and
// the closing step. Signed decimal also waits on the binary-to-BCD converter (two bits
// a cycle) from its start step, which overlaps the minus sign. cmd.ready is high whenever
// no command is in progress, and the last transfer may still wait in the output register
// then. Commands that emit nothing (undefined opcodes, out-of-range set cursor, trimmed
// binary of zero) finish with no transaction. Write nibble_mode only while no command
// is in progress.
module char_lcd_command_sequencer #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    clcd_cmd_if.sink    cmd,
    clcd_xfer_if.source xfer,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import clcd_pkg::*;

    logic               nibble_mode_reg, nibble_mode_next;
    oq_req_t            req;
    logic               room;
    logic               bcd_start;
    logic [VALUE_W-1:0] bcd_mag;
    logic               bcd_busy;
    logic [BCD_W-1:0]   bcd_digits;

    always_comb
    begin
        nibble_mode_next = cfg_we ? cfg_wdata : nibble_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nibble_mode_reg <= 1'b0;
        end
        else
        begin
            nibble_mode_reg <= nibble_mode_next;
        end
    end

    clcd_sequencer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .nibble_mode (nibble_mode_reg),
        .req         (req),
        .room        (room),
        .bcd_start   (bcd_start),
        .bcd_mag     (bcd_mag),
        .bcd_busy    (bcd_busy),
        .bcd_digits  (bcd_digits)
    );

    clcd_bcd_conv u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bcd_start),
        .mag    (bcd_mag),
        .busy   (bcd_busy),
        .digits (bcd_digits)
    );

    clcd_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .room  (room),
        .xfer  (xfer)
    );

endmodule
